[hdl/priority_inheritance_engine_unit_macros.svh]
// Assertion helpers for the top-level file, which carries the checks.
`ifndef PRIORITY_INHERITANCE_ENGINE_UNIT_MACROS_SVH
`define PRIORITY_INHERITANCE_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PIEU_ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
`define PIEU_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define PIEU_ASSERT_IMPLY(lbl, clk, rst_n, pre, post)
`define PIEU_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

[hdl/pieu_pkg.sv]
`timescale 1ns / 1ps
package pieu_pkg;

    localparam int THREAD_COUNT = 64;
    localparam int LOCK_COUNT   = 64;
    localparam int CHAIN_DEPTH  = 8;
    localparam int TOP_PRIORITY = 63;

    localparam int PW  = 6;
    localparam int TIW = (THREAD_COUNT > 1) ? $clog2(THREAD_COUNT) : 1;
    localparam int LIW = (LOCK_COUNT > 1) ? $clog2(LOCK_COUNT) : 1;
    localparam int MAX_COUNT = (THREAD_COUNT > LOCK_COUNT) ? THREAD_COUNT : LOCK_COUNT;
    localparam int SCW = $clog2(MAX_COUNT + 1);
    localparam int DW  = $clog2(CHAIN_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_INIT     = 3'd0,
        OP_SET_BASE = 3'd1,
        OP_BLOCK    = 3'd2,
        OP_UNBLOCK  = 3'd3,
        OP_ACQUIRE  = 3'd4,
        OP_RELEASE  = 3'd5
    } t_opcode;

    typedef struct packed {
        logic [2:0]    opcode;
        logic [5:0]    thread_id;
        logic [5:0]    lock_id;
        logic [PW-1:0] priority_value;
    } t_in_item;

    typedef struct packed {
        logic          status;
        logic [5:0]    settled_thread;
        logic [PW-1:0] effective_priority;
        logic [PW-1:0] base_level;
        logic          requeue;
    } t_out_item;

    typedef struct packed {
        logic [PW-1:0]  base;
        logic [PW-1:0]  eff;
        logic           waiting;
        logic [LIW-1:0] won;
    } t_thread_rec;

    typedef struct packed {
        logic           held;
        logic [TIW-1:0] holder;
        logic [PW-1:0]  prio;
    } t_lock_rec;

    typedef enum logic [4:0] {
        UOP_NONE,
        UOP_CAPTURE,
        UOP_T_INIT_WR,
        UOP_T_BASE,
        UOP_T_WAIT,
        UOP_T_UNWAIT_WR,
        UOP_LAT_T,
        UOP_LAT_L,
        UOP_L_ACQ,
        UOP_L_REL_WR,
        UOP_WT_FROM_L,
        UOP_WL_FROM_T,
        UOP_SCT_INIT,
        UOP_SCT_RUN,
        UOP_TFIN_WR,
        UOP_SCL_INIT,
        UOP_SCL_RUN,
        UOP_LFIN_WR,
        UOP_REQ,
        UOP_ERR,
        UOP_EMIT
    } t_uop;

    typedef struct packed {
        t_uop uop;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       t_ok;
        logic       l_ok;
        logic       p_ok;
        logic       th_waiting;
        logic       lk_held;
        logic       scan_done;
        logic       depth_done;
        logic       out_free;
    } t_dp_status;

endpackage

[hdl/pieu_ram.sv]
`timescale 1ns / 1ps
module pieu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/pieu_dp.sv]
`timescale 1ns / 1ps
module pieu_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  pieu_pkg::t_in_item   i_in_data,
    input  pieu_pkg::t_dp_cmd    i_cmd,
    output pieu_pkg::t_dp_status o_status,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output pieu_pkg::t_out_item  o_out_data
);

    localparam int TW = $bits(pieu_pkg::t_thread_rec);
    localparam int LW = $bits(pieu_pkg::t_lock_rec);

    logic [2:0]                   r_op;
    logic [5:0]                   r_tid;
    logic [5:0]                   r_lid;
    logic [pieu_pkg::PW-1:0]      r_pv;
    logic [pieu_pkg::TIW-1:0]     r_wt;
    logic [pieu_pkg::LIW-1:0]     r_wl;
    pieu_pkg::t_thread_rec        r_th;
    pieu_pkg::t_lock_rec          r_lk;
    logic [pieu_pkg::PW-1:0]      r_best;
    logic [pieu_pkg::SCW-1:0]     r_cnt;
    logic [pieu_pkg::SCW-1:0]     r_lim;
    logic                         r_pend;
    logic [pieu_pkg::DW-1:0]      r_depth;
    logic                         r_req;
    logic                         r_err;
    logic                         r_out_valid;
    pieu_pkg::t_out_item          r_out;
    logic [pieu_pkg::THREAD_COUNT-1:0] r_tvalid;
    logic [pieu_pkg::LOCK_COUNT-1:0]   r_lvalid;
    logic                         r_trd_ok;
    logic                         r_lrd_ok;

    logic                         w_t_we;
    pieu_pkg::t_thread_rec        w_t_wdata;
    logic [pieu_pkg::TIW-1:0]     w_t_raddr;
    logic [TW-1:0]                w_t_q;
    logic                         w_l_we;
    pieu_pkg::t_lock_rec          w_l_wdata;
    logic [pieu_pkg::LIW-1:0]     w_l_raddr;
    logic [LW-1:0]                w_l_q;
    pieu_pkg::t_thread_rec        w_trd;
    pieu_pkg::t_lock_rec          w_lrd;

    // Entries never written read as zero.
    assign w_trd = r_trd_ok ? pieu_pkg::t_thread_rec'(w_t_q) : '0;
    assign w_lrd = r_lrd_ok ? pieu_pkg::t_lock_rec'(w_l_q) : '0;

    assign w_t_raddr = (i_cmd.uop == pieu_pkg::UOP_SCL_RUN) ? r_cnt[pieu_pkg::TIW-1:0] : r_wt;
    assign w_l_raddr = (i_cmd.uop == pieu_pkg::UOP_SCT_RUN) ? r_cnt[pieu_pkg::LIW-1:0] : r_wl;

    always_comb begin
        w_t_we    = 1'b0;
        w_t_wdata = r_th;
        w_l_we    = 1'b0;
        w_l_wdata = r_lk;
        case (i_cmd.uop)
            pieu_pkg::UOP_T_INIT_WR: begin
                w_t_we            = 1'b1;
                w_t_wdata.base    = r_pv;
                w_t_wdata.eff     = r_pv;
                w_t_wdata.waiting = 1'b0;
                w_t_wdata.won     = '0;
            end
            pieu_pkg::UOP_T_UNWAIT_WR: begin
                w_t_we            = 1'b1;
                w_t_wdata.waiting = 1'b0;
                w_t_wdata.won     = '0;
            end
            pieu_pkg::UOP_TFIN_WR: begin
                w_t_we        = 1'b1;
                w_t_wdata.eff = r_best;
            end
            pieu_pkg::UOP_L_REL_WR: begin
                w_l_we           = 1'b1;
                w_l_wdata.held   = 1'b0;
                w_l_wdata.holder = '0;
            end
            pieu_pkg::UOP_LFIN_WR: begin
                w_l_we         = 1'b1;
                w_l_wdata.prio = r_best;
            end
            default: begin
            end
        endcase
    end

    pieu_ram #(
        .WIDTH (TW),
        .DEPTH (pieu_pkg::THREAD_COUNT)
    ) u_thread_ram (
        .i_clk   (i_clk),
        .i_we    (w_t_we),
        .i_waddr (r_wt),
        .i_wdata (w_t_wdata),
        .i_raddr (w_t_raddr),
        .o_rdata (w_t_q)
    );

    pieu_ram #(
        .WIDTH (LW),
        .DEPTH (pieu_pkg::LOCK_COUNT)
    ) u_lock_ram (
        .i_clk   (i_clk),
        .i_we    (w_l_we),
        .i_waddr (r_wl),
        .i_wdata (w_l_wdata),
        .i_raddr (w_l_raddr),
        .o_rdata (w_l_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid    <= '0;
            r_lvalid    <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            if (w_t_we) begin
                r_tvalid[r_wt] <= 1'b1;
            end
            if (w_l_we) begin
                r_lvalid[r_wl] <= 1'b1;
            end
            if (i_cmd.uop == pieu_pkg::UOP_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.uop == pieu_pkg::UOP_SCT_INIT || i_cmd.uop == pieu_pkg::UOP_SCL_INIT) begin
                r_pend <= 1'b0;
            end else if (i_cmd.uop == pieu_pkg::UOP_SCT_RUN ||
                         i_cmd.uop == pieu_pkg::UOP_SCL_RUN) begin
                r_pend <= (r_cnt != r_lim);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_trd_ok <= r_tvalid[w_t_raddr];
        r_lrd_ok <= r_lvalid[w_l_raddr];
        case (i_cmd.uop)
            pieu_pkg::UOP_CAPTURE: begin
                r_op    <= i_in_data.opcode;
                r_tid   <= i_in_data.thread_id;
                r_lid   <= i_in_data.lock_id;
                r_pv    <= i_in_data.priority_value;
                r_wt    <= pieu_pkg::TIW'(i_in_data.thread_id);
                r_wl    <= pieu_pkg::LIW'(i_in_data.lock_id);
                r_req   <= 1'b0;
                r_err   <= 1'b0;
                r_depth <= '0;
            end
            pieu_pkg::UOP_T_INIT_WR, pieu_pkg::UOP_T_UNWAIT_WR, pieu_pkg::UOP_TFIN_WR: begin
                r_th <= w_t_wdata;
            end
            pieu_pkg::UOP_T_BASE: r_th.base <= r_pv;
            pieu_pkg::UOP_T_WAIT: begin
                r_th.waiting <= 1'b1;
                r_th.won     <= r_wl;
            end
            pieu_pkg::UOP_LAT_T: r_th <= w_trd;
            pieu_pkg::UOP_LAT_L: r_lk <= w_lrd;
            pieu_pkg::UOP_L_ACQ: begin
                r_lk.held   <= 1'b1;
                r_lk.holder <= r_wt;
            end
            pieu_pkg::UOP_L_REL_WR, pieu_pkg::UOP_LFIN_WR: r_lk <= w_l_wdata;
            pieu_pkg::UOP_WT_FROM_L: r_wt <= r_lk.holder;
            pieu_pkg::UOP_WL_FROM_T: begin
                r_wl    <= r_th.won;
                r_depth <= r_depth + pieu_pkg::DW'(1);
            end
            pieu_pkg::UOP_SCT_INIT: begin
                r_cnt  <= '0;
                r_lim  <= pieu_pkg::SCW'(pieu_pkg::LOCK_COUNT);
                r_best <= r_th.base;
            end
            pieu_pkg::UOP_SCL_INIT: begin
                r_cnt  <= '0;
                r_lim  <= pieu_pkg::SCW'(pieu_pkg::THREAD_COUNT);
                r_best <= '0;
            end
            pieu_pkg::UOP_SCT_RUN: begin
                if (r_pend && w_lrd.held && w_lrd.holder == r_wt && w_lrd.prio > r_best) begin
                    r_best <= w_lrd.prio;
                end
                if (r_cnt != r_lim) begin
                    r_cnt <= r_cnt + pieu_pkg::SCW'(1);
                end
            end
            pieu_pkg::UOP_SCL_RUN: begin
                if (r_pend && w_trd.waiting && w_trd.won == r_wl && w_trd.eff > r_best) begin
                    r_best <= w_trd.eff;
                end
                if (r_cnt != r_lim) begin
                    r_cnt <= r_cnt + pieu_pkg::SCW'(1);
                end
            end
            pieu_pkg::UOP_REQ: r_req <= 1'b1;
            pieu_pkg::UOP_ERR: r_err <= 1'b1;
            pieu_pkg::UOP_EMIT: begin
                if (r_err) begin
                    r_out.status             <= 1'b1;
                    r_out.settled_thread     <= '0;
                    r_out.effective_priority <= '0;
                    r_out.base_level         <= '0;
                    r_out.requeue            <= 1'b0;
                end else begin
                    r_out.status             <= 1'b0;
                    r_out.settled_thread     <= 6'(r_wt);
                    r_out.effective_priority <= r_th.eff;
                    r_out.base_level         <= r_th.base;
                    r_out.requeue            <= r_req;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_status.op         = r_op;
        o_status.t_ok       = int'(r_tid) < pieu_pkg::THREAD_COUNT;
        o_status.l_ok       = int'(r_lid) < pieu_pkg::LOCK_COUNT;
        o_status.p_ok       = int'(r_pv) <= pieu_pkg::TOP_PRIORITY;
        o_status.th_waiting = r_th.waiting;
        o_status.lk_held    = r_lk.held;
        o_status.scan_done  = (r_cnt == r_lim) && !r_pend;
        o_status.depth_done = int'(r_depth) == pieu_pkg::CHAIN_DEPTH;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[hdl/pieu_ctrl.sv]
`timescale 1ns / 1ps
module pieu_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  pieu_pkg::t_dp_status i_status,
    output pieu_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [26:0] {
        S_IDLE  = 27'd1,
        S_CHECK = 27'd2,
        S_RDT   = 27'd4,
        S_LATT  = 27'd8,
        S_RDL   = 27'd16,
        S_LATL  = 27'd32,
        S_SCT0  = 27'd64,
        S_SCT   = 27'd128,
        S_TFIN  = 27'd256,
        S_SCL0  = 27'd512,
        S_SCL   = 27'd1024,
        S_LFIN  = 27'd2048,
        S_SB1   = 27'd4096,
        S_BK1   = 27'd8192,
        S_BK2   = 27'd16384,
        S_BK3   = 27'd32768,
        S_BK4   = 27'd65536,
        S_BK5   = 27'd131072,
        S_BK6   = 27'd262144,
        S_UB1   = 27'd524288,
        S_UB2   = 27'd1048576,
        S_AQ1   = 27'd2097152,
        S_AQ2   = 27'd4194304,
        S_AQ3   = 27'd8388608,
        S_RL1   = 27'd16777216,
        S_RL2   = 27'd33554432,
        S_EMIT  = 27'd67108864
    } t_state;

    t_state         r_state;
    t_state         n_state;
    t_state         r_ret;
    t_state         n_ret;
    pieu_pkg::t_uop w_uop;

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        w_uop   = pieu_pkg::UOP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_uop   = pieu_pkg::UOP_CAPTURE;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                w_uop   = pieu_pkg::UOP_ERR;
                n_state = S_EMIT;
                unique case (i_status.op)
                    pieu_pkg::OP_INIT: begin
                        if (i_status.t_ok && i_status.p_ok) begin
                            w_uop = pieu_pkg::UOP_T_INIT_WR;
                        end
                    end
                    pieu_pkg::OP_SET_BASE: begin
                        if (i_status.t_ok && i_status.p_ok) begin
                            w_uop   = pieu_pkg::UOP_NONE;
                            n_state = S_RDT;
                            n_ret   = S_SB1;
                        end
                    end
                    pieu_pkg::OP_BLOCK: begin
                        if (i_status.t_ok && i_status.l_ok) begin
                            w_uop   = pieu_pkg::UOP_NONE;
                            n_state = S_RDT;
                            n_ret   = S_BK1;
                        end
                    end
                    pieu_pkg::OP_UNBLOCK: begin
                        if (i_status.t_ok) begin
                            w_uop   = pieu_pkg::UOP_NONE;
                            n_state = S_RDT;
                            n_ret   = S_UB1;
                        end
                    end
                    pieu_pkg::OP_ACQUIRE: begin
                        if (i_status.t_ok && i_status.l_ok) begin
                            w_uop   = pieu_pkg::UOP_NONE;
                            n_state = S_RDL;
                            n_ret   = S_AQ1;
                        end
                    end
                    pieu_pkg::OP_RELEASE: begin
                        if (i_status.l_ok) begin
                            w_uop   = pieu_pkg::UOP_NONE;
                            n_state = S_RDL;
                            n_ret   = S_RL1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RDT: n_state = S_LATT;
            S_LATT: begin
                w_uop   = pieu_pkg::UOP_LAT_T;
                n_state = r_ret;
            end
            S_RDL: n_state = S_LATL;
            S_LATL: begin
                w_uop   = pieu_pkg::UOP_LAT_L;
                n_state = r_ret;
            end
            S_SCT0: begin
                w_uop   = pieu_pkg::UOP_SCT_INIT;
                n_state = S_SCT;
            end
            S_SCT: begin
                w_uop = pieu_pkg::UOP_SCT_RUN;
                if (i_status.scan_done) begin
                    n_state = S_TFIN;
                end
            end
            S_TFIN: begin
                w_uop   = pieu_pkg::UOP_TFIN_WR;
                n_state = r_ret;
            end
            S_SCL0: begin
                w_uop   = pieu_pkg::UOP_SCL_INIT;
                n_state = S_SCL;
            end
            S_SCL: begin
                w_uop = pieu_pkg::UOP_SCL_RUN;
                if (i_status.scan_done) begin
                    n_state = S_LFIN;
                end
            end
            S_LFIN: begin
                w_uop   = pieu_pkg::UOP_LFIN_WR;
                n_state = r_ret;
            end
            S_SB1: begin
                if (i_status.th_waiting) begin
                    w_uop   = pieu_pkg::UOP_ERR;
                    n_state = S_EMIT;
                end else begin
                    w_uop   = pieu_pkg::UOP_T_BASE;
                    n_state = S_SCT0;
                    n_ret   = S_EMIT;
                end
            end
            S_BK1: begin
                if (i_status.th_waiting) begin
                    w_uop   = pieu_pkg::UOP_ERR;
                    n_state = S_EMIT;
                end else begin
                    w_uop   = pieu_pkg::UOP_T_WAIT;
                    n_state = S_SCT0;
                    n_ret   = S_BK2;
                end
            end
            S_BK2: begin
                n_state = S_RDL;
                n_ret   = S_BK3;
            end
            S_BK3: begin
                // Head of one hop along the holder chain; the current lock is loaded.
                if (!i_status.lk_held) begin
                    n_state = S_SCL0;
                    n_ret   = S_EMIT;
                end else if (i_status.depth_done) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_SCL0;
                    n_ret   = S_BK4;
                end
            end
            S_BK4: begin
                w_uop   = pieu_pkg::UOP_WT_FROM_L;
                n_state = S_RDT;
                n_ret   = S_BK5;
            end
            S_BK5: begin
                n_state = S_SCT0;
                if (!i_status.th_waiting) begin
                    w_uop = pieu_pkg::UOP_REQ;
                    n_ret = S_EMIT;
                end else begin
                    n_ret = S_BK6;
                end
            end
            S_BK6: begin
                w_uop   = pieu_pkg::UOP_WL_FROM_T;
                n_state = S_RDL;
                n_ret   = S_BK3;
            end
            S_UB1: begin
                if (!i_status.th_waiting) begin
                    w_uop   = pieu_pkg::UOP_ERR;
                    n_state = S_EMIT;
                end else begin
                    w_uop   = pieu_pkg::UOP_WL_FROM_T;
                    n_state = S_RDL;
                    n_ret   = S_UB2;
                end
            end
            S_UB2: begin
                if (i_status.lk_held) begin
                    w_uop   = pieu_pkg::UOP_ERR;
                    n_state = S_EMIT;
                end else begin
                    w_uop   = pieu_pkg::UOP_T_UNWAIT_WR;
                    n_state = S_SCL0;
                    n_ret   = S_EMIT;
                end
            end
            S_AQ1: begin
                if (i_status.lk_held) begin
                    w_uop   = pieu_pkg::UOP_ERR;
                    n_state = S_EMIT;
                end else begin
                    w_uop   = pieu_pkg::UOP_L_ACQ;
                    n_state = S_SCL0;
                    n_ret   = S_AQ2;
                end
            end
            S_AQ2: begin
                n_state = S_RDT;
                n_ret   = S_AQ3;
            end
            S_AQ3: begin
                n_state = S_SCT0;
                n_ret   = S_EMIT;
            end
            S_RL1: begin
                if (!i_status.lk_held) begin
                    w_uop   = pieu_pkg::UOP_ERR;
                    n_state = S_EMIT;
                end else begin
                    w_uop   = pieu_pkg::UOP_WT_FROM_L;
                    n_state = S_RDT;
                    n_ret   = S_RL2;
                end
            end
            S_RL2: begin
                if (i_status.th_waiting) begin
                    w_uop   = pieu_pkg::UOP_ERR;
                    n_state = S_EMIT;
                end else begin
                    w_uop   = pieu_pkg::UOP_L_REL_WR;
                    n_state = S_SCT0;
                    n_ret   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    w_uop   = pieu_pkg::UOP_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret   <= S_IDLE;
        end else begin
            r_state <= n_state;
            r_ret   <= n_ret;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd.uop  = w_uop;

endmodule

[hdl/priority_inheritance_engine_unit.sv]
`timescale 1ns / 1ps
// One operation at a time; a new beat is taken only while the sequencer is idle.
// Every refresh scan walks one table (64 entries, one read a cycle), and a block
// follows the holder chain for up to eight hops. Results leave via an output register.
// Synchronous active-low reset clears the controller, the per-entry valid bits and the output valid flag.
`include "priority_inheritance_engine_unit_macros.svh"
module priority_inheritance_engine_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pieu_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pieu_pkg::t_out_item o_out_data
);

    pieu_pkg::t_dp_cmd    w_cmd;
    pieu_pkg::t_dp_status w_status;

    pieu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pieu_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    `PIEU_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `PIEU_ASSERT_IMPLY(a_emit_needs_slot, i_clk, i_rst_n, w_cmd.uop == pieu_pkg::UOP_EMIT, w_status.out_free)
    `PIEU_ASSERT_IMPLY(a_scan_while_busy, i_clk, i_rst_n, w_cmd.uop == pieu_pkg::UOP_SCT_RUN || w_cmd.uop == pieu_pkg::UOP_SCL_RUN, !o_in_ready)
    `PIEU_ASSERT_IMPLY(a_error_fields_clear, i_clk, i_rst_n, o_out_valid && o_out_data.status, o_out_data.settled_thread == 6'd0 && o_out_data.requeue == 1'b0)

endmodule
